### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the LCD bus controller. Assertions are compiled in
// simulation and drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Expression must never be true on a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### hw/rtl/lcdbus_pkg.sv
// ----------------------------------------------------------------------------
// lcdbus_pkg
// Types, codes and constants shared by the LCD parallel bus controller.
// ----------------------------------------------------------------------------
package lcdbus_pkg;

    // Request opcodes.
    localparam logic [1:0] OP_CMD        = 2'd0;
    localparam logic [1:0] OP_CMD_NOWAIT = 2'd1;
    localparam logic [1:0] OP_WRITE_DATA = 2'd2;
    localparam logic [1:0] OP_READ_DATA  = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_WIRE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_DELAY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_US = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUSY_TIMEOUT = 2'd3;

    // Configuration reset values.
    localparam logic        RST_FOUR_WIRE    = 1'b0;
    localparam logic [7:0]  RST_ENABLE_DELAY = 8'd8;
    localparam logic [9:0]  RST_TICKS_PER_US = 10'd50;
    localparam logic [15:0] RST_BUSY_TIMEOUT = 16'd1000;

    // Low nibble mask and the saturation point of the wait counter.
    localparam logic [7:0]  LOW_NIBBLE = 8'h0F;
    localparam logic [16:0] POLL_MAX   = 17'h1FFFF;

    // Bus sequencer phases.
    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_BF_SETUP  = 5'd1,
        PH_BF_SAMPLE = 5'd2,
        PH_BF_WAIT   = 5'd3,
        PH_BF_LOW    = 5'd4,
        PH_BF_HIGH2  = 5'd5,
        PH_BF_LOW2   = 5'd6,
        PH_WR_SETUP  = 5'd7,
        PH_WR_HIGH1  = 5'd8,
        PH_WR_LOW1   = 5'd9,
        PH_WR_HIGH2  = 5'd10,
        PH_RD_SETUP  = 5'd11,
        PH_RD_HIGH1  = 5'd12,
        PH_RD_LOW1   = 5'd13,
        PH_RD_HIGH2  = 5'd14,
        PH_DONE_OK   = 5'd15,
        PH_DONE_FAIL = 5'd16
    } phase_t;

    // One tick request: request strobe, opcode, byte to send and sampled pins.
    typedef struct packed {
        logic       req_valid;
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic [7:0] bus_in;
    } req_t;

    // Pin levels and status for one tick.
    typedef struct packed {
        logic       rs_pin;
        logic       rw_pin;
        logic       enable_pin;
        logic [7:0] bus_out;
        logic       bus_drive;
        logic       busy_res;
        logic       done_res;
        logic       ok;
        logic [7:0] read_value;
    } res_t;

    // Configuration register set.
    typedef struct packed {
        logic        four_wire;
        logic [7:0]  enable_delay_ticks;
        logic [9:0]  ticks_per_us;
        logic [15:0] busy_timeout;
    } cfg_t;

    // Datapath commands from the sequencer.
    typedef struct packed {
        logic load;
        logic delay_inc;
        logic us_inc;
        logic poll_inc;
        logic rd_cap_hi;
        logic rd_cap_lo;
    } cmd_t;

    // Pin controls from the sequencer.
    typedef struct packed {
        logic rs;
        logic rw;
        logic en;
        logic drive;
        logic wr_on;
        logic second;
        logic busy;
        logic done;
        logic ok;
        logic rd_show;
    } pins_t;

    // Datapath status back to the sequencer.
    typedef struct packed {
        logic [1:0] held_op;
        logic       level_last;
        logic       us_last;
        logic       timeout;
        logic       busy_flag;
        logic       four_wire;
    } status_t;

endpackage

### hw/rtl/lcdbus_ctrl.sv
// ----------------------------------------------------------------------------
// lcdbus_ctrl
// Bus sequencer: phase register, next-phase decisions, datapath commands and
// pin controls for the current phase.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcdbus_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 req_valid,
    input  logic [1:0]           req_op,
    input  lcdbus_pkg::status_t  status,
    output lcdbus_pkg::cmd_t     cmd,
    output lcdbus_pkg::pins_t    pins
);

    lcdbus_pkg::phase_t phase_reg;
    lcdbus_pkg::phase_t phase_next;

    // Phase register advances once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lcdbus_pkg::PH_IDLE;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
        end
    end

    // Next phase, datapath commands and pin levels.
    always_comb
    begin
        phase_next = phase_reg;
        cmd        = '0;
        pins       = '0;
        pins.drive = 1'b1;
        pins.busy  = (phase_reg != lcdbus_pkg::PH_IDLE);

        case (phase_reg)
            lcdbus_pkg::PH_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = (req_op == lcdbus_pkg::OP_CMD_NOWAIT) ?
                                 lcdbus_pkg::PH_WR_SETUP : lcdbus_pkg::PH_BF_SETUP;
                end
            end
            lcdbus_pkg::PH_BF_SETUP:
            begin
                pins.rw = 1'b1; pins.en = 1'b1; pins.drive = 1'b0;
                cmd.delay_inc = !status.level_last;
                if (status.level_last)
                begin
                    phase_next = lcdbus_pkg::PH_BF_SAMPLE;
                end
            end
            lcdbus_pkg::PH_BF_SAMPLE:
            begin
                pins.rw = 1'b1; pins.en = 1'b1; pins.drive = 1'b0;
                if (status.busy_flag)
                begin
                    phase_next = lcdbus_pkg::PH_BF_WAIT;
                end
                else if (status.held_op == lcdbus_pkg::OP_READ_DATA)
                begin
                    phase_next = lcdbus_pkg::PH_RD_SETUP;
                end
                else
                begin
                    phase_next = lcdbus_pkg::PH_WR_SETUP;
                end
            end
            lcdbus_pkg::PH_BF_WAIT:
            begin
                pins.rw = 1'b1; pins.en = 1'b1; pins.drive = 1'b0;
                cmd.us_inc = !status.us_last;
                if (status.us_last)
                begin
                    cmd.poll_inc = 1'b1;
                    phase_next   = status.timeout ?
                                   lcdbus_pkg::PH_DONE_FAIL : lcdbus_pkg::PH_BF_LOW;
                end
            end
            lcdbus_pkg::PH_BF_LOW:
            begin
                pins.rw = 1'b1; pins.drive = 1'b0;
                cmd.delay_inc = !status.level_last;
                if (status.level_last)
                begin
                    phase_next = status.four_wire ?
                                 lcdbus_pkg::PH_BF_HIGH2 : lcdbus_pkg::PH_BF_SAMPLE;
                end
            end
            lcdbus_pkg::PH_BF_HIGH2:
            begin
                pins.rw = 1'b1; pins.en = 1'b1; pins.drive = 1'b0;
                cmd.delay_inc = !status.level_last;
                if (status.level_last)
                begin
                    phase_next = lcdbus_pkg::PH_BF_LOW2;
                end
            end
            lcdbus_pkg::PH_BF_LOW2:
            begin
                pins.rw = 1'b1; pins.drive = 1'b0;
                cmd.delay_inc = !status.level_last;
                if (status.level_last)
                begin
                    phase_next = lcdbus_pkg::PH_BF_SAMPLE;
                end
            end
            lcdbus_pkg::PH_WR_SETUP:
            begin
                pins.rs    = (status.held_op == lcdbus_pkg::OP_WRITE_DATA);
                pins.wr_on = 1'b1;
                phase_next = lcdbus_pkg::PH_WR_HIGH1;
            end
            lcdbus_pkg::PH_WR_HIGH1:
            begin
                pins.rs    = (status.held_op == lcdbus_pkg::OP_WRITE_DATA);
                pins.en    = 1'b1;
                pins.wr_on = 1'b1;
                cmd.delay_inc = !status.level_last;
                if (status.level_last)
                begin
                    phase_next = status.four_wire ?
                                 lcdbus_pkg::PH_WR_LOW1 : lcdbus_pkg::PH_DONE_OK;
                end
            end
            lcdbus_pkg::PH_WR_LOW1:
            begin
                pins.rs     = (status.held_op == lcdbus_pkg::OP_WRITE_DATA);
                pins.wr_on  = 1'b1;
                pins.second = 1'b1;
                cmd.delay_inc = !status.level_last;
                if (status.level_last)
                begin
                    phase_next = lcdbus_pkg::PH_WR_HIGH2;
                end
            end
            lcdbus_pkg::PH_WR_HIGH2:
            begin
                pins.rs     = (status.held_op == lcdbus_pkg::OP_WRITE_DATA);
                pins.en     = 1'b1;
                pins.wr_on  = 1'b1;
                pins.second = 1'b1;
                cmd.delay_inc = !status.level_last;
                if (status.level_last)
                begin
                    phase_next = lcdbus_pkg::PH_DONE_OK;
                end
            end
            lcdbus_pkg::PH_RD_SETUP:
            begin
                pins.rs = 1'b1; pins.rw = 1'b1; pins.drive = 1'b0;
                phase_next = lcdbus_pkg::PH_RD_HIGH1;
            end
            lcdbus_pkg::PH_RD_HIGH1:
            begin
                pins.rs = 1'b1; pins.rw = 1'b1; pins.en = 1'b1; pins.drive = 1'b0;
                cmd.delay_inc = !status.level_last;
                if (status.level_last)
                begin
                    cmd.rd_cap_hi = 1'b1;
                    phase_next    = status.four_wire ?
                                    lcdbus_pkg::PH_RD_LOW1 : lcdbus_pkg::PH_DONE_OK;
                end
            end
            lcdbus_pkg::PH_RD_LOW1:
            begin
                pins.rs = 1'b1; pins.rw = 1'b1; pins.drive = 1'b0;
                cmd.delay_inc = !status.level_last;
                if (status.level_last)
                begin
                    phase_next = lcdbus_pkg::PH_RD_HIGH2;
                end
            end
            lcdbus_pkg::PH_RD_HIGH2:
            begin
                pins.rs = 1'b1; pins.rw = 1'b1; pins.en = 1'b1; pins.drive = 1'b0;
                cmd.delay_inc = !status.level_last;
                if (status.level_last)
                begin
                    cmd.rd_cap_lo = 1'b1;
                    phase_next    = lcdbus_pkg::PH_DONE_OK;
                end
            end
            lcdbus_pkg::PH_DONE_OK:
            begin
                pins.done    = 1'b1;
                pins.ok      = 1'b1;
                pins.rd_show = (status.held_op == lcdbus_pkg::OP_READ_DATA);
                phase_next   = lcdbus_pkg::PH_IDLE;
            end
            lcdbus_pkg::PH_DONE_FAIL:
            begin
                pins.done  = 1'b1;
                phase_next = lcdbus_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = lcdbus_pkg::PH_IDLE;
            end
        endcase
    end

    // A finish tick always returns the sequencer to idle.
    `ASSERT_PROP(a_done_to_idle, clk, rst_n, step && pins.done |=> phase_reg == lcdbus_pkg::PH_IDLE)

    // A microsecond wait that is not over keeps the sequencer waiting.
    `ASSERT_PROP(a_wait_holds, clk, rst_n, step && phase_reg == lcdbus_pkg::PH_BF_WAIT && !status.us_last |=> phase_reg == lcdbus_pkg::PH_BF_WAIT)

    // A new request is loaded only while idle.
    `ASSERT_NEVER(a_load_only_idle, clk, rst_n, cmd.load && phase_reg != lcdbus_pkg::PH_IDLE)

endmodule

### hw/rtl/lcdbus_dp.sv
// ----------------------------------------------------------------------------
// lcdbus_dp
// Datapath: held request, enable-delay, microsecond and wait counters, read
// byte assembly, and the pin values for the current tick.
// ----------------------------------------------------------------------------
module lcdbus_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  lcdbus_pkg::req_t     item,
    input  lcdbus_pkg::cfg_t     cfg,
    input  lcdbus_pkg::cmd_t     cmd,
    input  lcdbus_pkg::pins_t    pins,
    output lcdbus_pkg::status_t  status,
    output lcdbus_pkg::res_t     res
);

    logic [1:0]  held_op_reg,   held_op_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic [7:0]  delay_reg,     delay_next;
    logic [9:0]  us_reg,        us_next;
    logic [16:0] poll_reg,      poll_next;
    logic [7:0]  rd_reg,        rd_next;

    logic [7:0]  delay_eff;
    logic [9:0]  tpu_eff;
    logic [16:0] poll_plus;
    logic [7:0]  lo_part;
    logic [7:0]  wr_value;

    // Zero delays count as one tick; the wait counter saturates.
    always_comb
    begin
        delay_eff = (cfg.enable_delay_ticks == 8'd0) ? 8'd1 : cfg.enable_delay_ticks;
        tpu_eff   = (cfg.ticks_per_us == 10'd0) ? 10'd1 : cfg.ticks_per_us;
        poll_plus = (poll_reg == lcdbus_pkg::POLL_MAX) ? poll_reg : poll_reg + 17'd1;
    end

    // Status for the sequencer.
    always_comb
    begin
        status.held_op    = held_op_reg;
        status.level_last = ({1'b0, delay_reg} + 9'd1) >= {1'b0, delay_eff};
        status.us_last    = ({1'b0, us_reg} + 11'd1) >= {1'b0, tpu_eff};
        status.timeout    = poll_plus > {1'b0, cfg.busy_timeout};
        status.busy_flag  = item.bus_in[7];
        status.four_wire  = cfg.four_wire;
    end

    // Counter and capture updates.
    always_comb
    begin
        held_op_next   = held_op_reg;
        held_byte_next = held_byte_reg;
        delay_next     = cmd.delay_inc ? delay_reg + 8'd1 : 8'd0;
        us_next        = cmd.us_inc ? us_reg + 10'd1 : 10'd0;
        poll_next      = poll_reg;
        rd_next        = rd_reg;
        if (cmd.load)
        begin
            held_op_next   = item.op;
            held_byte_next = item.tx_byte;
            poll_next      = 17'd0;
            rd_next        = 8'd0;
        end
        if (cmd.poll_inc)
        begin
            poll_next = poll_plus;
        end
        if (cmd.rd_cap_hi)
        begin
            rd_next = cfg.four_wire ? (item.bus_in & ~lcdbus_pkg::LOW_NIBBLE) : item.bus_in;
        end
        if (cmd.rd_cap_lo)
        begin
            rd_next = {rd_reg[7:4], item.bus_in[7:4]};
        end
    end

    // Datapath registers advance once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_op_reg   <= 2'd0;
            held_byte_reg <= 8'd0;
            delay_reg     <= 8'd0;
            us_reg        <= 10'd0;
            poll_reg      <= 17'd0;
            rd_reg        <= 8'd0;
        end
        else if (step)
        begin
            held_op_reg   <= held_op_next;
            held_byte_reg <= held_byte_next;
            delay_reg     <= delay_next;
            us_reg        <= us_next;
            poll_reg      <= poll_next;
            rd_reg        <= rd_next;
        end
    end

    // Write value: whole byte, or high then low nibble on D7..D4.
    always_comb
    begin
        lo_part = held_byte_reg & lcdbus_pkg::LOW_NIBBLE;
        if (!cfg.four_wire)
        begin
            wr_value = held_byte_reg;
        end
        else if (pins.second)
        begin
            wr_value = {lo_part[3:0], 4'h0};
        end
        else
        begin
            wr_value = held_byte_reg & ~lcdbus_pkg::LOW_NIBBLE;
        end
    end

    // Pin values for this tick.
    always_comb
    begin
        res.rs_pin     = pins.rs;
        res.rw_pin     = pins.rw;
        res.enable_pin = pins.en;
        res.bus_out    = pins.wr_on ? wr_value : 8'd0;
        res.bus_drive  = pins.drive;
        res.busy_res   = pins.busy;
        res.done_res   = pins.done;
        res.ok         = pins.ok;
        res.read_value = pins.rd_show ? rd_reg : 8'd0;
    end

endmodule

### hw/rtl/char_lcd_parallel_bus_controller.sv
// ----------------------------------------------------------------------------
// char_lcd_parallel_bus_controller
// Character-LCD parallel bus controller: one request per tick carries the
// sampled pins, one result per tick carries the pin levels to drive.
//
//   Port group   Direction  Handshake                  Payload
//   item         in         item_valid / item_stall    lcdbus_pkg::req_t
//   result       out        result_valid / result_stall lcdbus_pkg::res_t
//   cfg          in         cfg_we                     cfg_index, cfg_data
//
// A new request is taken every cycle while the result register is empty or
// being drained. The result register is the only stage between the channels,
// so a stalled result stalls the input side.
// Reset (rst_n low) returns the sequencer to idle and loads the default
// configuration. Bus timing is counted in requests, not clock cycles.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module char_lcd_parallel_bus_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  lcdbus_pkg::req_t                     item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output lcdbus_pkg::res_t                     result,
    input  logic                                 cfg_we,
    input  logic [lcdbus_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lcdbus_pkg::CFG_DATA_W-1:0]    cfg_data
);

    lcdbus_pkg::cfg_t     cfg_reg;
    lcdbus_pkg::cmd_t     cmd;
    lcdbus_pkg::pins_t    pins;
    lcdbus_pkg::status_t  status;
    lcdbus_pkg::res_t     res;
    lcdbus_pkg::res_t     result_reg;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    logic                 step;

    // Input is taken whenever the result register can take a new result.
    assign item_stall = result_valid_reg && result_stall;
    assign step       = item_valid && !item_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.four_wire          <= lcdbus_pkg::RST_FOUR_WIRE;
            cfg_reg.enable_delay_ticks <= lcdbus_pkg::RST_ENABLE_DELAY;
            cfg_reg.ticks_per_us       <= lcdbus_pkg::RST_TICKS_PER_US;
            cfg_reg.busy_timeout       <= lcdbus_pkg::RST_BUSY_TIMEOUT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lcdbus_pkg::CFG_FOUR_WIRE:    cfg_reg.four_wire          <= cfg_data[0];
                lcdbus_pkg::CFG_ENABLE_DELAY: cfg_reg.enable_delay_ticks <= cfg_data[7:0];
                lcdbus_pkg::CFG_TICKS_PER_US: cfg_reg.ticks_per_us       <= cfg_data[9:0];
                lcdbus_pkg::CFG_BUSY_TIMEOUT: cfg_reg.busy_timeout       <= cfg_data[15:0];
                default:                      cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // Sequencer.
    lcdbus_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .req_valid (item.req_valid),
        .req_op    (item.op),
        .status    (status),
        .cmd       (cmd),
        .pins      (pins)
    );

    // Counters, held request and pin values.
    lcdbus_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .cfg    (cfg_reg),
        .cmd    (cmd),
        .pins   (pins),
        .status (status),
        .res    (res)
    );

    // Result register.
    always_comb
    begin
        if (step)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Every accepted request leaves a result behind.
    `ASSERT_PROP(a_accept_gives_result, clk, rst_n, step |=> result_valid)

    // A held result that is stalled blocks the input side.
    `ASSERT_PROP(a_stall_blocks_input, clk, rst_n, result_valid && result_stall |-> item_stall)

    // The bus is never driven while the display is strobed for a read.
    `ASSERT_NEVER(a_no_drive_on_read, clk, rst_n, result_valid && result.enable_pin && result.rw_pin && result.bus_drive)

endmodule

### bench/tb_char_lcd_parallel_bus_controller.sv
// ----------------------------------------------------------------------------
// tb_char_lcd_parallel_bus_controller
// Self-checking bench for the character-LCD parallel bus controller. Each
// request is one bus tick. A cycle model of the bus sequencer predicts the pin
// levels for every accepted request, and each result is checked against the
// oldest prediction. Directed tests cover the reset configuration, every
// opcode, busy-flag polling and timeout, four-wire nibble transfers, zero
// delays, requests offered while busy and the slowest settings. A random
// phase follows, under several configurations. Both channels idle and stall
// at random.
// ----------------------------------------------------------------------------
module tb_char_lcd_parallel_bus_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [7:0] HIGH_NIBBLE    = ~lcdbus_pkg::LOW_NIBBLE;
    localparam logic [7:0] BUSY_FLAG      = 8'h80;

    logic                               clk;
    logic                               rst_n;
    logic                               item_valid;
    logic                               item_stall;
    lcdbus_pkg::req_t                   item;
    logic                               result_valid;
    logic                               result_stall;
    lcdbus_pkg::res_t                   result;
    logic                               cfg_we;
    logic [lcdbus_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lcdbus_pkg::CFG_DATA_W-1:0]  cfg_data;

    // Configuration copy held by the sequencer model.
    logic        m_four_wire;
    logic [7:0]  m_enable_delay;
    logic [9:0]  m_ticks_per_us;
    logic [15:0] m_busy_timeout;

    // Sequencer model state.
    lcdbus_pkg::phase_t seq_ph;
    logic [1:0]  cur_op;
    logic [7:0]  cur_byte;
    logic [7:0]  dly_cnt;
    logic [9:0]  us_cnt;
    logic [16:0] wait_cnt;
    logic [7:0]  rd_acc;

    // Predicted pin levels, oldest first.
    lcdbus_pkg::res_t pin_levels_q[$];
    lcdbus_pkg::res_t want_pins;
    lcdbus_pkg::res_t new_pins;

    int err_count   = 0;
    int ticks_sent  = 0;
    int burst_left  = 0;
    bit pace_on     = 1'b0;
    int stall_left  = 0;
    int idle_cycles = 0;

    char_lcd_parallel_bus_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------------

    // Enters a phase and restarts the level counter.
    function automatic void goto_phase(lcdbus_pkg::phase_t p);
        seq_ph  = p;
        dly_cnt = '0;
    endfunction

    // Counts one tick of an enable level; true on its last tick.
    function automatic bit level_last();
        int d;
        d = (m_enable_delay == 8'd0) ? 1 : int'(m_enable_delay);
        if (int'(dly_cnt) + 1 >= d)
        begin
            dly_cnt = '0;
            return 1'b1;
        end
        dly_cnt = dly_cnt + 8'd1;
        return 1'b0;
    endfunction

    // Byte or nibble placed on the bus during a write.
    function automatic logic [7:0] write_bus(bit second);
        if (!m_four_wire)
            return cur_byte;
        if (!second)
            return cur_byte & HIGH_NIBBLE;
        return (cur_byte & lcdbus_pkg::LOW_NIBBLE) << 4;
    endfunction

    // Pin levels shown during this tick, taken from the state at its start.
    function automatic lcdbus_pkg::res_t lcd_pin_levels();
        lcdbus_pkg::res_t p;
        p           = '0;
        p.bus_drive = 1'b1;
        p.busy_res  = (seq_ph != lcdbus_pkg::PH_IDLE);
        case (seq_ph)
            lcdbus_pkg::PH_BF_SETUP, lcdbus_pkg::PH_BF_SAMPLE,
            lcdbus_pkg::PH_BF_WAIT, lcdbus_pkg::PH_BF_HIGH2:
            begin
                p.rw_pin     = 1'b1;
                p.enable_pin = 1'b1;
                p.bus_drive  = 1'b0;
            end
            lcdbus_pkg::PH_BF_LOW, lcdbus_pkg::PH_BF_LOW2:
            begin
                p.rw_pin    = 1'b1;
                p.bus_drive = 1'b0;
            end
            lcdbus_pkg::PH_WR_SETUP, lcdbus_pkg::PH_WR_HIGH1:
            begin
                p.rs_pin     = (cur_op == lcdbus_pkg::OP_WRITE_DATA);
                p.enable_pin = (seq_ph == lcdbus_pkg::PH_WR_HIGH1);
                p.bus_out    = write_bus(1'b0);
            end
            lcdbus_pkg::PH_WR_LOW1, lcdbus_pkg::PH_WR_HIGH2:
            begin
                p.rs_pin     = (cur_op == lcdbus_pkg::OP_WRITE_DATA);
                p.enable_pin = (seq_ph == lcdbus_pkg::PH_WR_HIGH2);
                p.bus_out    = write_bus(1'b1);
            end
            lcdbus_pkg::PH_RD_SETUP, lcdbus_pkg::PH_RD_LOW1:
            begin
                p.rs_pin    = 1'b1;
                p.rw_pin    = 1'b1;
                p.bus_drive = 1'b0;
            end
            lcdbus_pkg::PH_RD_HIGH1, lcdbus_pkg::PH_RD_HIGH2:
            begin
                p.rs_pin     = 1'b1;
                p.rw_pin     = 1'b1;
                p.enable_pin = 1'b1;
                p.bus_drive  = 1'b0;
            end
            lcdbus_pkg::PH_DONE_OK:
            begin
                p.done_res   = 1'b1;
                p.ok         = 1'b1;
                p.read_value = (cur_op == lcdbus_pkg::OP_READ_DATA) ? rd_acc : 8'd0;
            end
            lcdbus_pkg::PH_DONE_FAIL:
                p.done_res = 1'b1;
            default:
                ;
        endcase
        return p;
    endfunction

    // Moves the sequencer model on by one tick.
    function automatic void step_sequencer(lcdbus_pkg::req_t it);
        int tpu;
        case (seq_ph)
            lcdbus_pkg::PH_IDLE:
                if (it.req_valid)
                begin
                    cur_op   = it.op;
                    cur_byte = it.tx_byte;
                    wait_cnt = '0;
                    us_cnt   = '0;
                    rd_acc   = '0;
                    if (it.op == lcdbus_pkg::OP_CMD_NOWAIT)
                        goto_phase(lcdbus_pkg::PH_WR_SETUP);
                    else
                        goto_phase(lcdbus_pkg::PH_BF_SETUP);
                end
            lcdbus_pkg::PH_BF_SETUP:
                if (level_last())
                    goto_phase(lcdbus_pkg::PH_BF_SAMPLE);
            lcdbus_pkg::PH_BF_SAMPLE:
                if (it.bus_in[7])
                begin
                    us_cnt = '0;
                    goto_phase(lcdbus_pkg::PH_BF_WAIT);
                end
                else if (cur_op == lcdbus_pkg::OP_READ_DATA)
                    goto_phase(lcdbus_pkg::PH_RD_SETUP);
                else
                    goto_phase(lcdbus_pkg::PH_WR_SETUP);
            lcdbus_pkg::PH_BF_WAIT:
            begin
                tpu = (m_ticks_per_us == 10'd0) ? 1 : int'(m_ticks_per_us);
                if (int'(us_cnt) + 1 >= tpu)
                begin
                    us_cnt = '0;
                    if (wait_cnt < lcdbus_pkg::POLL_MAX)
                        wait_cnt = wait_cnt + 17'd1;
                    if (wait_cnt > {1'b0, m_busy_timeout})
                        goto_phase(lcdbus_pkg::PH_DONE_FAIL);
                    else
                        goto_phase(lcdbus_pkg::PH_BF_LOW);
                end
                else
                    us_cnt = us_cnt + 10'd1;
            end
            lcdbus_pkg::PH_BF_LOW:
                if (level_last())
                begin
                    if (m_four_wire)
                        goto_phase(lcdbus_pkg::PH_BF_HIGH2);
                    else
                        goto_phase(lcdbus_pkg::PH_BF_SAMPLE);
                end
            lcdbus_pkg::PH_BF_HIGH2:
                if (level_last())
                    goto_phase(lcdbus_pkg::PH_BF_LOW2);
            lcdbus_pkg::PH_BF_LOW2:
                if (level_last())
                    goto_phase(lcdbus_pkg::PH_BF_SAMPLE);
            lcdbus_pkg::PH_WR_SETUP:
                goto_phase(lcdbus_pkg::PH_WR_HIGH1);
            lcdbus_pkg::PH_WR_HIGH1:
                if (level_last())
                begin
                    if (m_four_wire)
                        goto_phase(lcdbus_pkg::PH_WR_LOW1);
                    else
                        goto_phase(lcdbus_pkg::PH_DONE_OK);
                end
            lcdbus_pkg::PH_WR_LOW1:
                if (level_last())
                    goto_phase(lcdbus_pkg::PH_WR_HIGH2);
            lcdbus_pkg::PH_WR_HIGH2:
                if (level_last())
                    goto_phase(lcdbus_pkg::PH_DONE_OK);
            lcdbus_pkg::PH_RD_SETUP:
                goto_phase(lcdbus_pkg::PH_RD_HIGH1);
            lcdbus_pkg::PH_RD_HIGH1:
                if (level_last())
                begin
                    if (m_four_wire)
                    begin
                        rd_acc = it.bus_in & HIGH_NIBBLE;
                        goto_phase(lcdbus_pkg::PH_RD_LOW1);
                    end
                    else
                    begin
                        rd_acc = it.bus_in;
                        goto_phase(lcdbus_pkg::PH_DONE_OK);
                    end
                end
            lcdbus_pkg::PH_RD_LOW1:
                if (level_last())
                    goto_phase(lcdbus_pkg::PH_RD_HIGH2);
            lcdbus_pkg::PH_RD_HIGH2:
                if (level_last())
                begin
                    rd_acc = (rd_acc & HIGH_NIBBLE) |
                             ((it.bus_in >> 4) & lcdbus_pkg::LOW_NIBBLE);
                    goto_phase(lcdbus_pkg::PH_DONE_OK);
                end
            default:
                goto_phase(lcdbus_pkg::PH_IDLE);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    // Results are checked before the request of the same edge is predicted,
    // since a result always belongs to an earlier request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pin_levels_q.size() == 0)
                begin
                    $error("result with no prediction waiting");
                    err_count++;
                end
                else
                begin
                    want_pins = pin_levels_q.pop_front();
                    check_field("rs_pin", 8'(want_pins.rs_pin), 8'(result.rs_pin));
                    check_field("rw_pin", 8'(want_pins.rw_pin), 8'(result.rw_pin));
                    check_field("enable_pin", 8'(want_pins.enable_pin),
                                8'(result.enable_pin));
                    check_field("bus_out", want_pins.bus_out, result.bus_out);
                    check_field("bus_drive", 8'(want_pins.bus_drive),
                                8'(result.bus_drive));
                    check_field("busy_res", 8'(want_pins.busy_res), 8'(result.busy_res));
                    check_field("done_res", 8'(want_pins.done_res), 8'(result.done_res));
                    check_field("ok", 8'(want_pins.ok), 8'(result.ok));
                    check_field("read_value", want_pins.read_value, result.read_value);
                end
            end
            if (item_valid && !item_stall)
            begin
                new_pins = lcd_pin_levels();
                step_sequencer(item);
                pin_levels_q.push_back(new_pins);
            end
        end
    end

    // Watchdog on cycles in which no request, result or write moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver stall pattern: free runs, short and long stalls, long clear stretches.
    always @(negedge clk)
    begin
        int pick;
        if (stall_left > 0)
            stall_left--;
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                result_stall <= 1'b0;
                stall_left = $urandom_range(1, 30);
            end
            else if (pick < 8)
            begin
                result_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else if (pick == 8)
            begin
                result_stall <= 1'b1;
                stall_left = $urandom_range(3, 11);
            end
            else
            begin
                result_stall <= 1'b0;
                stall_left = $urandom_range(60, 200);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Sends one bus tick; called and returning just after a falling edge.
    task automatic send_tick(lcdbus_pkg::req_t it);
        int gap;
        if (pace_on && burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        ticks_sent++;
        @(negedge clk);
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic wait_quiet();
        item_valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pin_levels_q.size() != 0)
            @(negedge clk);
    endtask

    // Writes one register; the write enable is left high for the caller.
    task automatic write_reg(logic [lcdbus_pkg::CFG_INDEX_W-1:0] idx,
                             logic [lcdbus_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            lcdbus_pkg::CFG_FOUR_WIRE:    m_four_wire    = val[0];
            lcdbus_pkg::CFG_ENABLE_DELAY: m_enable_delay = val[7:0];
            lcdbus_pkg::CFG_TICKS_PER_US: m_ticks_per_us = val[9:0];
            lcdbus_pkg::CFG_BUSY_TIMEOUT: m_busy_timeout = val[15:0];
            default:                      ;
        endcase
        @(negedge clk);
    endtask

    // Reconfigures the block once it has gone quiet.
    task automatic apply_cfg(logic fw, logic [7:0] dly, logic [9:0] tpu, logic [15:0] bto);
        wait_quiet();
        write_reg(lcdbus_pkg::CFG_FOUR_WIRE, {15'd0, fw});
        write_reg(lcdbus_pkg::CFG_ENABLE_DELAY, {8'd0, dly});
        write_reg(lcdbus_pkg::CFG_TICKS_PER_US, {6'd0, tpu});
        write_reg(lcdbus_pkg::CFG_BUSY_TIMEOUT, bto);
        cfg_we <= 1'b0;
    endtask

    // Issues one request and feeds bus ticks until the sequencer is idle again.
    // The busy flag is reported on the first n_busy samples; the display
    // returns rd_val on reads. Other ticks carry random bus noise, and
    // noise_pct percent of them offer a stray request, which must be ignored.
    task automatic run_request(logic [1:0] op, logic [7:0] tx_val, int n_busy,
                               logic [7:0] rd_val, int noise_pct);
        lcdbus_pkg::req_t it;
        int   busy_left;
        busy_left  = n_busy;
        it.req_valid = 1'b1;
        it.op        = op;
        it.tx_byte   = tx_val;
        it.bus_in    = 8'($urandom);
        send_tick(it);
        while (seq_ph != lcdbus_pkg::PH_IDLE)
        begin
            it.req_valid = ($urandom_range(0, 99) < noise_pct);
            it.op        = 2'($urandom);
            it.tx_byte   = 8'($urandom);
            it.bus_in    = 8'($urandom);
            case (seq_ph)
                lcdbus_pkg::PH_BF_SAMPLE:
                    if (busy_left > 0)
                    begin
                        it.bus_in = it.bus_in | BUSY_FLAG;
                        busy_left--;
                    end
                    else
                        it.bus_in = it.bus_in & ~BUSY_FLAG;
                lcdbus_pkg::PH_RD_HIGH1:
                    if (m_four_wire)
                        it.bus_in = {rd_val[7:4], it.bus_in[3:0]};
                    else
                        it.bus_in = rd_val;
                lcdbus_pkg::PH_RD_HIGH2:
                    it.bus_in = {rd_val[3:0], it.bus_in[3:0]};
                default:
                    ;
            endcase
            send_tick(it);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_reset_defaults();
        run_request(lcdbus_pkg::OP_CMD, 8'h01, 1, 8'h00, 0);
        run_request(lcdbus_pkg::OP_CMD_NOWAIT, 8'h38, 0, 8'h00, 0);
    endtask

    task automatic test_ops_full_bus();
        apply_cfg(1'b0, 8'd1, 10'd1, 16'd3);
        run_request(lcdbus_pkg::OP_CMD, 8'h00, 0, 8'h00, 0);
        run_request(lcdbus_pkg::OP_CMD_NOWAIT, 8'hFF, 0, 8'h00, 0);
        run_request(lcdbus_pkg::OP_WRITE_DATA, 8'hA5, 2, 8'h00, 0);
        run_request(lcdbus_pkg::OP_READ_DATA, 8'h00, 0, 8'hFF, 0);
        run_request(lcdbus_pkg::OP_READ_DATA, 8'hFF, 1, 8'h00, 0);
    endtask

    task automatic test_busy_timeout();
        apply_cfg(1'b0, 8'd1, 10'd2, 16'd0);
        run_request(lcdbus_pkg::OP_CMD, 8'h5A, 1, 8'h00, 0);
        apply_cfg(1'b1, 8'd2, 10'd1, 16'd2);
        run_request(lcdbus_pkg::OP_READ_DATA, 8'h00, 3, 8'h3C, 0);
        run_request(lcdbus_pkg::OP_WRITE_DATA, 8'hC3, 2, 8'h00, 0);
    endtask

    task automatic test_four_wire();
        apply_cfg(1'b1, 8'd1, 10'd1, 16'd2);
        run_request(lcdbus_pkg::OP_WRITE_DATA, 8'h5A, 0, 8'h00, 0);
        run_request(lcdbus_pkg::OP_READ_DATA, 8'h00, 1, 8'hC3, 0);
        run_request(lcdbus_pkg::OP_CMD, 8'hFF, 0, 8'h00, 0);
        run_request(lcdbus_pkg::OP_CMD_NOWAIT, 8'h0F, 0, 8'h00, 0);
    endtask

    // Zero delay and zero ticks per microsecond both count as one tick.
    task automatic test_zero_delays();
        apply_cfg(1'b0, 8'd0, 10'd0, 16'd0);
        run_request(lcdbus_pkg::OP_CMD, 8'h80, 1, 8'h00, 0);
        run_request(lcdbus_pkg::OP_READ_DATA, 8'h00, 0, 8'h96, 0);
        apply_cfg(1'b1, 8'd0, 10'd0, 16'd1);
        run_request(lcdbus_pkg::OP_READ_DATA, 8'h00, 1, 8'h69, 0);
    endtask

    task automatic test_request_while_busy();
        apply_cfg(1'b1, 8'd2, 10'd2, 16'd3);
        run_request(lcdbus_pkg::OP_WRITE_DATA, 8'hE7, 2, 8'h00, 100);
        run_request(lcdbus_pkg::OP_READ_DATA, 8'h00, 1, 8'h7E, 100);
    endtask

    // The slowest settings, with an unchecked command on the full bus.
    task automatic test_slow_extremes();
        apply_cfg(1'b0, 8'd255, 10'd1023, 16'd65535);
        run_request(lcdbus_pkg::OP_CMD_NOWAIT, 8'hA5, 0, 8'h00, 5);
    endtask

    task automatic test_random_traffic();
        int   ph;
        int   budget_end;
        int   n_busy;
        int   pick;
        bit   paused;
        lcdbus_pkg::req_t it;
        logic [7:0]  dly;
        logic [9:0]  tpu;
        logic [15:0] bto;
        paused = 1'b0;
        for (ph = 0; ph < 8; ph++)
        begin
            pick = $urandom_range(0, 4);
            dly  = (pick < 4) ? 8'(pick) : 8'($urandom_range(1, 6));
            pick = $urandom_range(0, 3);
            tpu  = (pick < 3) ? 10'(pick) : 10'($urandom_range(1, 5));
            pick = $urandom_range(0, 4);
            bto  = (pick < 3) ? 16'(pick) : 16'($urandom_range(0, 8));
            if (ph == 7)
                bto = 16'd65535;
            apply_cfg(1'($urandom), dly, tpu, bto);
            budget_end = ticks_sent + 45;
            while (ticks_sent < budget_end)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // Idle ticks with noise on the bus.
                    repeat ($urandom_range(1, 4))
                    begin
                        it.req_valid = 1'b0;
                        it.op        = 2'($urandom);
                        it.tx_byte   = 8'($urandom);
                        it.bus_in    = 8'($urandom);
                        send_tick(it);
                    end
                end
                else
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        n_busy = 0;
                    else if (pick < 9 || m_busy_timeout > 16'd6)
                        n_busy = $urandom_range(1, 3);
                    else
                        n_busy = int'(m_busy_timeout) + 1 + $urandom_range(0, 1);
                    run_request(2'($urandom), 8'($urandom), n_busy, 8'($urandom),
                                $urandom_range(0, 30));
                end
                // Hold off once until the pipeline has drained completely.
                if (ph == 2 && !paused)
                begin
                    wait_quiet();
                    paused = 1'b1;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;

        m_four_wire    = lcdbus_pkg::RST_FOUR_WIRE;
        m_enable_delay = lcdbus_pkg::RST_ENABLE_DELAY;
        m_ticks_per_us = lcdbus_pkg::RST_TICKS_PER_US;
        m_busy_timeout = lcdbus_pkg::RST_BUSY_TIMEOUT;
        seq_ph         = lcdbus_pkg::PH_IDLE;
        cur_op         = '0;
        cur_byte       = '0;
        dly_cnt        = '0;
        us_cnt         = '0;
        wait_cnt       = '0;
        rd_acc         = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        pace_on = 1'b1;
        test_reset_defaults();
        test_ops_full_bus();
        test_busy_timeout();
        test_four_wire();
        test_zero_delays();
        test_request_while_busy();
        test_slow_extremes();
        test_random_traffic();

        wait_quiet();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
